// ===== design/utfva_pkg.sv =====
// Shared types, byte codes and the accented-letter fold table for the UTF-8 folder.
`default_nettype none
package utfva_pkg;

  // Lead and continuation byte codes
  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [7:0] LEAD_C6 = 8'hC6;
  localparam logic [7:0] LEAD_E1 = 8'hE1;
  localparam logic [7:0] CONT_BA = 8'hBA;
  localparam logic [7:0] CONT_BB = 8'hBB;

  // Table rows
  localparam logic [2:0] ROW_C3   = 3'd0;
  localparam logic [2:0] ROW_C4   = 3'd1;
  localparam logic [2:0] ROW_C5   = 3'd2;
  localparam logic [2:0] ROW_C6   = 3'd3;
  localparam logic [2:0] ROW_E1BA = 3'd4;
  localparam logic [2:0] ROW_E1BB = 3'd5;

  // Held byte counts
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_LEAD = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // Upper-case base letters; lower case sets bit 5
  localparam logic [6:0] CH_A = 7'h41;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_E = 7'h45;
  localparam logic [6:0] CH_I = 7'h49;
  localparam logic [6:0] CH_O = 7'h4F;
  localparam logic [6:0] CH_U = 7'h55;
  localparam logic [6:0] CH_Y = 7'h59;
  localparam logic [6:0] CASE_BIT = 7'h20;

  typedef struct packed {
    logic       start;
    logic [7:0] text_byte;
  } utfva_req_t;

  typedef struct packed {
    logic       emit;
    logic [6:0] ascii_char;
  } utfva_res_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } fold_t;

  // Fold one sequence to its base letter; idx is the last byte's low six bits.
  function automatic fold_t fold_lookup(input logic [2:0] row, input logic [5:0] idx);
    fold_t      r;
    logic [4:0] lo;
    logic       lower;
    logic [6:0] base;
    logic       hit;
    lo    = idx[4:0];
    lower = idx[0];
    base  = CH_A;
    hit   = 1'b0;
    case (row)
      ROW_C3: begin
        lower = idx[5];
        hit   = 1'b1;
        if (lo <= 5'd3) base = CH_A;
        else if (lo >= 5'd8 && lo <= 5'd10) base = CH_E;
        else if (lo == 5'd12 || lo == 5'd13) base = CH_I;
        else if (lo >= 5'd18 && lo <= 5'd21) base = CH_O;
        else if (lo == 5'd25 || lo == 5'd26) base = CH_U;
        else if (lo == 5'd29) base = CH_Y;
        else hit = 1'b0;
      end
      ROW_C4: begin
        hit = 1'b1;
        if (idx == 6'd2 || idx == 6'd3) base = CH_A;
        else if (idx == 6'd16 || idx == 6'd17) base = CH_D;
        else if (idx == 6'd40 || idx == 6'd41) base = CH_I;
        else hit = 1'b0;
      end
      ROW_C5: begin
        base = CH_U;
        hit  = (idx == 6'd40 || idx == 6'd41);
      end
      ROW_C6: begin
        hit   = 1'b1;
        lower = (idx == 6'd33 || idx == 6'd48);
        if (idx == 6'd32 || idx == 6'd33) base = CH_O;
        else if (idx == 6'd47 || idx == 6'd48) base = CH_U;
        else hit = 1'b0;
      end
      ROW_E1BA: begin
        hit  = idx[5];
        base = (idx < 6'd56) ? CH_A : CH_E;
      end
      ROW_E1BB: begin
        hit = 1'b1;
        if (idx < 6'd8) base = CH_E;
        else if (idx < 6'd12) base = CH_I;
        else if (idx < 6'd36) base = CH_O;
        else if (idx < 6'd50) base = CH_U;
        else if (idx < 6'd58) base = CH_Y;
        else hit = 1'b0;
      end
      default: hit = 1'b0;
    endcase
    r.hit = hit;
    r.ch  = lower ? (base | CASE_BIT) : base;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/utfva_fold.sv =====
// Sequence tracker: pending UTF-8 bytes and the per-byte fold decision.
`default_nettype none
module utfva_fold (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               commit,
  input  wire utfva_pkg::utfva_req_t req,
  output utfva_pkg::utfva_res_t   res
);
  import utfva_pkg::*;

  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] second_byte, second_byte_next;
  logic [1:0] bytes_held, bytes_held_next;

  logic [7:0] lb, sb, b;
  logic [1:0] bh;
  logic       lead_two;
  logic       do_lookup;
  logic [2:0] row;
  fold_t      lk;

  assign b  = req.text_byte;
  assign lb = req.start ? 8'd0 : lead_byte;
  assign sb = req.start ? 8'd0 : second_byte;
  assign bh = req.start ? HELD_NONE : bytes_held;
  assign lead_two = (lb >= LEAD_C3) && (lb <= LEAD_C6);
  assign lk = fold_lookup(row, b[5:0]);

  always_comb begin
    lead_byte_next   = 8'd0;
    second_byte_next = 8'd0;
    bytes_held_next  = HELD_NONE;
    do_lookup        = 1'b0;
    row              = ROW_E1BB;
    res.emit         = 1'b0;
    res.ascii_char   = b[6:0];
    if (!b[7]) begin
      res.emit = 1'b1;
    end else if (((b >= LEAD_C3) && (b <= LEAD_C6)) || (b == LEAD_E1)) begin
      lead_byte_next  = b;
      bytes_held_next = HELD_LEAD;
    end else if (b[7:6] == 2'b10) begin
      if (bh == HELD_LEAD && lead_two) begin
        do_lookup = 1'b1;
        row       = 3'(lb - LEAD_C3);
      end else if (bh == HELD_LEAD && lb == LEAD_E1) begin
        if (b == CONT_BA || b == CONT_BB) begin
          lead_byte_next   = lb;
          second_byte_next = b;
          bytes_held_next  = HELD_TWO;
        end
      end else if (bh == HELD_TWO && lb == LEAD_E1 && (sb == CONT_BA || sb == CONT_BB)) begin
        do_lookup = 1'b1;
        row       = (sb == CONT_BA) ? ROW_E1BA : ROW_E1BB;
      end
    end
    if (do_lookup) begin
      res.emit       = lk.hit;
      res.ascii_char = lk.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte   <= 8'd0;
      second_byte <= 8'd0;
      bytes_held  <= HELD_NONE;
    end else if (commit) begin
      lead_byte   <= lead_byte_next;
      second_byte <= second_byte_next;
      bytes_held  <= bytes_held_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_vietnamese_to_ascii.sv =====
// Top level of the Vietnamese UTF-8 to ASCII folder with stream ports.
//
// Takes UTF-8 text one byte per request on the slave side and gives plain
// ASCII on the master side. ASCII bytes pass through and drop any pending
// sequence; a C3..C6 lead opens a two-byte sequence and E1 a three-byte one.
// A finished sequence that names one of the 134 accented Vietnamese letters
// yields its base letter; all other non-ASCII bytes and broken or unknown
// sequences are dropped with no output. tuser high on a request clears any
// pending sequence before that byte is decoded. Each byte is captured in an
// input register, is decoded by the sequence tracker and table lookup, and
// its result (if any) lands in the output register that drives m_tvalid;
// one byte is taken every cycle as long as the output register drains.
// Bytes that give no result never wait on m_tready.
`default_nettype none
module utf8_vietnamese_to_ascii (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tuser,   // [0] start_of_text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [6:0] ascii_char, [7] zero
);
  import utfva_pkg::*;

  // Input register
  logic       hold_valid;
  utfva_req_t hold;

  // Decode result of the held byte
  utfva_res_t res;
  logic       advance;
  logic       out_free;

  // Output register
  logic [6:0] out_char;

  utfva_fold u_fold (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (hold),
    .res    (res)
  );

  assign out_free = !m_tvalid || m_tready;
  // The held byte moves on unless it has a result and the output is full.
  assign advance  = hold_valid && (!res.emit || out_free);
  assign s_tready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold.text_byte <= s_tdata;
      hold.start     <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res.emit) begin
      out_char <= res.ascii_char;
    end
  end

  assign m_tdata = {1'b0, out_char};

`ifndef SYNTH
  // A byte with no result never holds up the input side.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid && !res.emit |-> s_tready)
    else $error("no-result byte stalled the input");

  // An ASCII byte that moves on appears unchanged at the output next cycle.
  assert property (@(posedge clk) disable iff (rst)
    advance && !hold.text_byte[7] |=> m_tvalid && (m_tdata[6:0] == $past(hold.text_byte[6:0])))
    else $error("ASCII byte not passed through");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  // A waiting result is never overwritten by a new one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(out_char))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
